### rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

   // command codes carried in the func field
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_STOP  = 3'd4;

   // register indexes on the configuration port
   localparam logic REG_HALF_BIT     = 1'b0;
   localparam logic REG_STRETCH_POLL = 1'b1;

   localparam logic [15:0] HALF_BIT_RESET     = 16'd5;
   localparam logic [15:0] STRETCH_POLL_RESET = 16'd4;

   localparam logic [7:0] BYTE_IDLE = 8'hFF;
   localparam logic [7:0] ACK_MASK  = 8'h01;

   localparam logic [3:0] BITS_DATA = 4'd8;
   localparam logic [3:0] BITS_ACK  = 4'd1;

   typedef enum logic [3:0] {
      PH_IDLE         = 4'd0,
      PH_START_POLL   = 4'd1,
      PH_START_STRETCH = 4'd2,
      PH_START_HOLD   = 4'd3,
      PH_BIT_LOW      = 4'd4,
      PH_BIT_HIGH     = 4'd5,
      PH_BIT_STRETCH  = 4'd6,
      PH_BIT_END      = 4'd7,
      PH_STOP_POLL    = 4'd8,
      PH_STOP_STRETCH = 4'd9,
      PH_STOP_END     = 4'd10
   } phase_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic       ack_received;
      logic [7:0] read_data;
   } result_type;

   typedef struct packed {
      logic [15:0] half_bit_ticks;
      logic [15:0] stretch_poll_ticks;
   } timing_type;

endpackage

`default_nettype wire

### rtl/i2cm_csr.sv
`default_nettype none

module i2cm_csr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic      [31:0]          prdata,
   output logic                      pready,
   output i2cm_pkg::timing_type      timing
);

   logic [15:0] half_bit_ff;
   logic [15:0] half_bit_in;
   logic [15:0] stretch_poll_ff;
   logic [15:0] stretch_poll_in;
   logic        write_en;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite;

   always_comb begin
      half_bit_in     = half_bit_ff;
      stretch_poll_in = stretch_poll_ff;
      if (write_en) begin
         unique case (paddr[2])
            i2cm_pkg::REG_HALF_BIT:     half_bit_in     = pwdata[15:0];
            i2cm_pkg::REG_STRETCH_POLL: stretch_poll_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         i2cm_pkg::REG_HALF_BIT:     prdata = {16'd0, half_bit_ff};
         i2cm_pkg::REG_STRETCH_POLL: prdata = {16'd0, stretch_poll_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ff     <= i2cm_pkg::HALF_BIT_RESET;
         stretch_poll_ff <= i2cm_pkg::STRETCH_POLL_RESET;
      end else begin
         half_bit_ff     <= half_bit_in;
         stretch_poll_ff <= stretch_poll_in;
      end
   end

   assign timing.half_bit_ticks     = half_bit_ff;
   assign timing.stretch_poll_ticks = stretch_poll_ff;

endmodule

`default_nettype wire

### rtl/i2cm_core.sv
`default_nettype none

module i2cm_core #(
   parameter int DELAY_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [2:0]           func,
   input  wire logic [6:0]           address,
   input  wire logic                 read_dir,
   input  wire logic [7:0]           data,
   input  wire logic                 scl_in,
   input  wire logic                 sda_in,
   input  wire i2cm_pkg::timing_type timing,
   output i2cm_pkg::result_type      result
);

   i2cm_pkg::phase_type    phase_ff, phase_in;
   logic [3:0]             bit_count_ff, bit_count_in;
   logic [7:0]             shift_ff, shift_in;
   logic [DELAY_WIDTH-1:0] delay_ff, delay_in;
   logic                   scl_rel_ff, scl_rel_in;
   logic                   sda_rel_ff, sda_rel_in;
   logic [2:0]             active_ff, active_in;
   logic                   drive_en_ff, drive_en_in;
   logic                   out_bit_ff, out_bit_in;
   logic [7:0]             rx_ff, rx_in;
   logic                   in_ack_ff, in_ack_in;

   logic                   expired;
   logic                   begin_req;
   logic [3:0]             begin_n;
   logic                   begin_drive;
   logic                   done;
   logic                   ack_out;
   logic [7:0]             rd_out;
   logic [7:0]             got;
   logic [DELAY_WIDTH-1:0] half_load;
   logic [DELAY_WIDTH-1:0] poll_load;

   // a zero in the register is loaded as one, so it acts like a value of one
   function automatic logic [DELAY_WIDTH-1:0] load_delay(input logic [15:0] v);
      logic [DELAY_WIDTH-1:0] t;
      t = DELAY_WIDTH'(v);
      return (t == '0) ? DELAY_WIDTH'(1) : t;
   endfunction

   assign half_load = load_delay(timing.half_bit_ticks);
   assign poll_load = load_delay(timing.stretch_poll_ticks);
   assign expired   = (delay_ff <= DELAY_WIDTH'(1));

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      delay_in     = delay_ff;
      scl_rel_in   = scl_rel_ff;
      sda_rel_in   = sda_rel_ff;
      active_in    = active_ff;
      drive_en_in  = drive_en_ff;
      out_bit_in   = out_bit_ff;
      rx_in        = rx_ff;
      in_ack_in    = in_ack_ff;
      begin_req    = 1'b0;
      begin_n      = i2cm_pkg::BITS_DATA;
      begin_drive  = 1'b0;
      done         = 1'b0;
      ack_out      = 1'b0;
      rd_out       = 8'd0;
      got          = shift_ff;

      unique case (phase_ff)
         i2cm_pkg::PH_IDLE: begin
            if (func == i2cm_pkg::CMD_START) begin
               active_in   = func;
               shift_in    = {address, read_dir};
               drive_en_in = 1'b0;
               scl_rel_in  = 1'b1;
               phase_in    = i2cm_pkg::PH_START_POLL;
            end else if (func == i2cm_pkg::CMD_WRITE) begin
               active_in   = func;
               shift_in    = data;
               in_ack_in   = 1'b0;
               begin_req   = 1'b1;
               begin_drive = 1'b1;
            end else if (func == i2cm_pkg::CMD_READ) begin
               active_in   = func;
               in_ack_in   = 1'b0;
               begin_req   = 1'b1;
            end else if (func == i2cm_pkg::CMD_STOP) begin
               active_in   = func;
               sda_rel_in  = 1'b0;
               scl_rel_in  = 1'b1;
               phase_in    = i2cm_pkg::PH_STOP_POLL;
            end
         end
         i2cm_pkg::PH_START_POLL: begin
            delay_in = poll_load;
            if (scl_in) begin
               sda_rel_in = 1'b0;
               phase_in   = i2cm_pkg::PH_START_HOLD;
            end else begin
               phase_in   = i2cm_pkg::PH_START_STRETCH;
            end
         end
         i2cm_pkg::PH_START_STRETCH: begin
            delay_in = expired ? '0 : delay_ff - DELAY_WIDTH'(1);
            if (expired) phase_in = i2cm_pkg::PH_START_POLL;
         end
         i2cm_pkg::PH_START_HOLD: begin
            delay_in = expired ? '0 : delay_ff - DELAY_WIDTH'(1);
            if (expired) begin
               sda_rel_in  = 1'b1;
               in_ack_in   = 1'b0;
               begin_req   = 1'b1;
               begin_drive = 1'b1;
            end
         end
         i2cm_pkg::PH_BIT_LOW: begin
            out_bit_in = shift_ff[7];
            delay_in   = expired ? '0 : delay_ff - DELAY_WIDTH'(1);
            if (expired) begin
               scl_rel_in = 1'b1;
               phase_in   = i2cm_pkg::PH_BIT_HIGH;
            end
         end
         i2cm_pkg::PH_BIT_HIGH: begin
            if (scl_in) begin
               shift_in     = {shift_ff[6:0], sda_in};
               scl_rel_in   = 1'b0;
               bit_count_in = (bit_count_ff != 4'd0) ? bit_count_ff - 4'd1 : 4'd0;
               delay_in     = half_load;
               phase_in     = (bit_count_in != 4'd0) ? i2cm_pkg::PH_BIT_LOW
                                                      : i2cm_pkg::PH_BIT_END;
            end else begin
               delay_in = poll_load;
               phase_in = i2cm_pkg::PH_BIT_STRETCH;
            end
         end
         i2cm_pkg::PH_BIT_STRETCH: begin
            delay_in = expired ? '0 : delay_ff - DELAY_WIDTH'(1);
            if (expired) phase_in = i2cm_pkg::PH_BIT_HIGH;
         end
         i2cm_pkg::PH_BIT_END: begin
            delay_in = expired ? '0 : delay_ff - DELAY_WIDTH'(1);
            if (expired) begin
               shift_in    = i2cm_pkg::BYTE_IDLE;
               out_bit_in  = 1'b1;
               drive_en_in = 1'b1;
               if (!in_ack_ff) begin
                  // byte done, clock the acknowledge bit next
                  in_ack_in = 1'b1;
                  begin_req = 1'b1;
                  begin_n   = i2cm_pkg::BITS_ACK;
                  if (active_ff == i2cm_pkg::CMD_READ) begin
                     rx_in       = got;
                     begin_drive = 1'b1;
                  end
               end else begin
                  in_ack_in = 1'b0;
                  done      = 1'b1;
                  if (active_ff == i2cm_pkg::CMD_READ) begin
                     rd_out = rx_ff;
                  end else begin
                     ack_out = ((got & i2cm_pkg::ACK_MASK) == 8'd0);
                  end
                  active_in = i2cm_pkg::CMD_TICK;
                  phase_in  = i2cm_pkg::PH_IDLE;
               end
            end
         end
         i2cm_pkg::PH_STOP_POLL: begin
            if (scl_in) begin
               sda_rel_in = 1'b1;
               delay_in   = half_load;
               phase_in   = i2cm_pkg::PH_STOP_END;
            end else begin
               delay_in   = poll_load;
               phase_in   = i2cm_pkg::PH_STOP_STRETCH;
            end
         end
         i2cm_pkg::PH_STOP_STRETCH: begin
            delay_in = expired ? '0 : delay_ff - DELAY_WIDTH'(1);
            if (expired) phase_in = i2cm_pkg::PH_STOP_POLL;
         end
         i2cm_pkg::PH_STOP_END: begin
            delay_in = expired ? '0 : delay_ff - DELAY_WIDTH'(1);
            if (expired) begin
               done      = 1'b1;
               active_in = i2cm_pkg::CMD_TICK;
               phase_in  = i2cm_pkg::PH_IDLE;
            end
         end
         default: phase_in = i2cm_pkg::PH_IDLE;
      endcase

      // enter the low half of the first bit of a byte or of the ack bit
      if (begin_req) begin
         scl_rel_in   = 1'b0;
         bit_count_in = begin_n;
         drive_en_in  = begin_drive;
         out_bit_in   = shift_in[7];
         delay_in     = half_load;
         phase_in     = i2cm_pkg::PH_BIT_LOW;
      end
   end

   assign result.scl_drive_low = ~scl_rel_in;
   assign result.sda_drive_low = ~sda_rel_in | (drive_en_in & ~out_bit_in);
   assign result.busy_res      = (phase_in != i2cm_pkg::PH_IDLE);
   assign result.done_res      = done;
   assign result.ack_received  = ack_out;
   assign result.read_data     = rd_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cm_pkg::PH_IDLE;
         bit_count_ff <= 4'd0;
         shift_ff     <= i2cm_pkg::BYTE_IDLE;
         delay_ff     <= '0;
         scl_rel_ff   <= 1'b1;
         sda_rel_ff   <= 1'b1;
         active_ff    <= i2cm_pkg::CMD_TICK;
         drive_en_ff  <= 1'b1;
         out_bit_ff   <= 1'b1;
         rx_ff        <= 8'd0;
         in_ack_ff    <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         delay_ff     <= delay_in;
         scl_rel_ff   <= scl_rel_in;
         sda_rel_ff   <= sda_rel_in;
         active_ff    <= active_in;
         drive_en_ff  <= drive_en_in;
         out_bit_ff   <= out_bit_in;
         rx_ff        <= rx_in;
         in_ack_ff    <= in_ack_in;
      end
   end

endmodule

`default_nettype wire

### rtl/i2c_master_byte_controller_unit.sv
`default_nettype none

// Two-wire bus master driven one tick per beat. Each request beat carries
// an optional command (start with address and direction, write byte, read
// byte, stop) and the sampled clock and data line levels; each beat yields
// exactly one response beat with the open-drain drives, busy, a done pulse,
// the acknowledge seen after a start or write, and the byte of a read
// (which always answers NACK). Commands that arrive while busy are dropped.
// Throughput is one beat per clock: the bus sequencer advances once per
// accepted beat through a single combinational step into the response
// register, and a new beat is taken whenever that register is empty or
// being drained. Responses are registered. Half-bit and stretch-poll delays
// count request beats, not clocks; program them through the register port
// (half_bit_ticks at 0x0, stretch_poll_ticks at 0x4) only while idle.
module i2c_master_byte_controller_unit #(
   parameter int DELAY_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_func,
   input  wire logic [6:0]  req_address,
   input  wire logic        req_read_dir,
   input  wire logic [7:0]  req_data,
   input  wire logic        req_scl_in,
   input  wire logic        req_sda_in,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_scl_drive_low,
   output logic             rsp_sda_drive_low,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic             rsp_ack_received,
   output logic [7:0]       rsp_read_data,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   i2cm_pkg::timing_type timing;
   i2cm_pkg::result_type step_result;
   i2cm_pkg::result_type result_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 accept;

   i2cm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .timing  (timing)
   );

   // take a beat whenever the response slot is free or empties this cycle
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   i2cm_core #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .func     (req_func),
      .address  (req_address),
      .read_dir (req_read_dir),
      .data     (req_data),
      .scl_in   (req_scl_in),
      .sda_in   (req_sda_in),
      .timing   (timing),
      .result   (step_result)
   );

   // hold the response until taken, refill on every accepted beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scl_drive_low = result_ff.scl_drive_low;
   assign rsp_sda_drive_low = result_ff.sda_drive_low;
   assign rsp_busy_res      = result_ff.busy_res;
   assign rsp_done_res      = result_ff.done_res;
   assign rsp_ack_received  = result_ff.ack_received;
   assign rsp_read_data     = result_ff.read_data;

endmodule

`default_nettype wire
